### hw/rtl/cfca_pkg.sv
// Shared types, constants and the byte-wise CRC update for the command frame CRC appender.
// Depends on nothing; used by every module of the block.
package cfca_pkg;

   localparam logic [15:0] SEED_AT_RESET = 16'h554D;
   localparam logic [7:0]  CHAR_OFFSET   = 8'h30;
   localparam logic [7:0]  END_MARKER    = 8'h03;

   // Output slot codes: which word of an item is shown on the result side.
   localparam logic [2:0] SLOT_DATA = 3'd0;
   localparam logic [2:0] SLOT_NIB3 = 3'd1;
   localparam logic [2:0] SLOT_NIB2 = 3'd2;
   localparam logic [2:0] SLOT_NIB1 = 3'd3;
   localparam logic [2:0] SLOT_NIB0 = 3'd4;
   localparam logic [2:0] SLOT_END  = 3'd5;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        end_of_message;
      logic [15:0] crc;
   } item_type;

   typedef struct packed {
      logic at_message_start;
   } crc_status_type;

   // Reflected CRC-16 (polynomial 0x8408), one byte per call.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0]  t;
      logic [15:0] w;
      t = crc[7:0] ^ b;
      t = t ^ {t[3:0], 4'b0000};
      w = {8'h00, t};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ (w << 3) ^ (w >> 4);
   endfunction

endpackage

### hw/rtl/cfca_crc_unit.sv
// Running checksum register and start-of-message flag with the byte update logic.
// Depends on cfca_pkg.
module cfca_crc_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    end_of_message,
   input  logic [15:0]             seed,
   output logic [15:0]             crc_next,
   output cfca_pkg::crc_status_type status
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic        start_ff;
   logic        start_in;

   // The start marker loads the seed and is not checksummed.
   assign crc_next = start_ff ? seed : cfca_pkg::crc_byte(crc_ff, data_byte);

   always_comb begin
      crc_in   = crc_ff;
      start_in = start_ff;
      if (accept) begin
         crc_in   = crc_next;
         start_in = end_of_message;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= cfca_pkg::SEED_AT_RESET;
         start_ff <= 1'b1;
      end else begin
         crc_ff   <= crc_in;
         start_ff <= start_in;
      end
   end

   assign status.at_message_start = start_ff;

endmodule

### hw/rtl/cfca_frame_out.sv
// Result register and tail sequencer: shows each byte, and after a flagged byte four checksum
// characters and the end marker. Depends on cfca_pkg.
module cfca_frame_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  cfca_pkg::item_type item,
   output logic               load_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               frame_last
);

   logic               valid_ff;
   logic               valid_in;
   logic [2:0]         slot_ff;
   logic [2:0]         slot_in;
   cfca_pkg::item_type item_ff;
   cfca_pkg::item_type item_in;
   logic               pop;
   logic               last_slot;
   logic [3:0]         nib;

   assign pop        = valid_ff && out_ready;
   assign last_slot  = item_ff.end_of_message ? (slot_ff == cfca_pkg::SLOT_END)
                                              : (slot_ff == cfca_pkg::SLOT_DATA);
   assign load_ready = !valid_ff || (out_ready && last_slot);

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      item_in  = item_ff;
      if (pop) begin
         if (last_slot) begin
            valid_in = 1'b0;
         end else begin
            slot_in = slot_ff + 3'd1;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         slot_in  = cfca_pkg::SLOT_DATA;
         item_in  = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= cfca_pkg::SLOT_DATA;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
      item_ff <= item_in;
   end

   always_comb begin
      nib        = 4'h0;
      out_byte   = item_ff.data_byte;
      frame_last = 1'b0;
      unique case (slot_ff)
         cfca_pkg::SLOT_DATA: out_byte = item_ff.data_byte;
         cfca_pkg::SLOT_NIB3: begin
            nib      = item_ff.crc[15:12];
            out_byte = {4'h0, nib} + cfca_pkg::CHAR_OFFSET;
         end
         cfca_pkg::SLOT_NIB2: begin
            nib      = item_ff.crc[11:8];
            out_byte = {4'h0, nib} + cfca_pkg::CHAR_OFFSET;
         end
         cfca_pkg::SLOT_NIB1: begin
            nib      = item_ff.crc[7:4];
            out_byte = {4'h0, nib} + cfca_pkg::CHAR_OFFSET;
         end
         cfca_pkg::SLOT_NIB0: begin
            nib      = item_ff.crc[3:0];
            out_byte = {4'h0, nib} + cfca_pkg::CHAR_OFFSET;
         end
         cfca_pkg::SLOT_END: begin
            out_byte   = cfca_pkg::END_MARKER;
            frame_last = 1'b1;
         end
         default: out_byte = item_ff.data_byte;
      endcase
   end

   assign out_valid = valid_ff;

endmodule

### hw/rtl/command_frame_crc_appender_unit.sv
// Top level of the command frame CRC appender: seed register, checksum unit and result sequencer.
// Depends on cfca_pkg, cfca_crc_unit and cfca_frame_out.
// An accepted word is registered and appears on the result side in the next cycle.
// Throughput: one word per cycle for bytes without the final flag while results are taken; a
// flagged byte yields six words (byte, four checksum characters, end marker) as the input waits.
// Reset (synchronous, active high) empties the result register, sets the seed to 0x554D
// and arms the checksum for a new message.
module command_frame_crc_appender_unit (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_message
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // frame_last
   // Seed register write port.
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                     req_accept;
   logic [15:0]              seed_ff;
   logic [15:0]              seed_in;
   logic [15:0]              crc_next;
   cfca_pkg::crc_status_type crc_status;
   cfca_pkg::item_type       item;

   // The seed register is only sampled at the start marker of a message, so a write in
   // the middle of a message takes effect with the next one.
   assign seed_in = csr_wr_en ? csr_wr_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= cfca_pkg::SEED_AT_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // A word is taken whenever the result register is empty or is handing over its final word.
   assign req_accept = req_tvalid && req_tready;

   cfca_crc_unit u_crc (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .data_byte      (req_tdata),
      .end_of_message (req_tlast),
      .seed           (seed_ff),
      .crc_next       (crc_next),
      .status         (crc_status)
   );

   // The checksum snapshot travels with the byte; only a flagged byte uses it.
   assign item.data_byte      = req_tdata;
   assign item.end_of_message = req_tlast;
   assign item.crc            = crc_next;

   cfca_frame_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .item       (item),
      .load_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .frame_last (rsp_tlast)
   );

   // The closing word of a frame is always the end marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == cfca_pkg::END_MARKER)
      else $error("frame_last on a word other than the end marker");

   // While the end marker is handed over, the checksum is already armed, so a byte taken
   // in the same cycle is treated as a start marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |-> crc_status.at_message_start)
      else $error("checksum not re-armed after end marker");

   // While a result is waiting, a new word is only taken as that result is being handed over.
   assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tready)
      else $error("input accepted over a stalled result");

   // A taken flagged byte starts a tail: a non-final result follows and the input is held.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> rsp_tvalid && !rsp_tlast && !req_tready)
      else $error("flagged byte did not start a checksum tail");

endmodule
